@@ hw/rtl/bctd_pkg.sv @@
// Shared types, constants and divide-by-constant helpers for the BC1/BC2/BC3 block decoder.
`timescale 1ns / 1ps
`default_nettype none

package bctd_pkg;

    localparam int S_DATA_W = 128;   // color_half, alpha_half
    localparam int M_DATA_W = 136;   // row_number, texel0..3, zero pad

    localparam logic [1:0] FMT_BC1  = 2'd0;
    localparam logic [1:0] FMT_BC2  = 2'd1;
    localparam logic [1:0] FMT_BC3  = 2'd2;
    localparam logic [1:0] LAST_ROW = 2'd3;

    // Decoded block as held while its rows go out.
    typedef struct packed {
        logic [1:0]        fmt;
        logic              three_color;  // BC1 three-color mode, entry 3 is transparent black
        logic [3:0][23:0]  rgb;          // {B, G, R} per palette entry
        logic [7:0][7:0]   atab;         // BC3 alpha table
        logic [31:0]       cidx;
        logic [63:0]       ahalf;
    } pal_t;

    // x <= 766: (x * 683) >> 11 is exact over this range.
    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [19:0] p;
        p = 20'(x) * 20'd683;
        return p[18:11];
    endfunction

    // x <= 1277
    function automatic logic [7:0] div5(input logic [10:0] x);
        logic [23:0] p;
        p = 24'(x) * 24'd3277;
        return p[21:14];
    endfunction

    // x <= 1788
    function automatic logic [7:0] div7(input logic [10:0] x);
        logic [23:0] p;
        p = 24'(x) * 24'd2341;
        return p[21:14];
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/bctd_palette.sv @@
// Two-stage palette: weighted sums, then reciprocal divides or halving into block register.
`timescale 1ns / 1ps
`default_nettype none

module bctd_palette (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic [1:0]              fmt_i,
    input  wire logic                    in_valid_i,
    output logic                         in_ready_o,
    input  wire logic [63:0]             color_half_i,
    input  wire logic [63:0]             alpha_half_i,
    output logic                         pal_valid_o,
    input  wire logic                    pal_ready_i,
    output bctd_pkg::pal_t               pal_o
);

    typedef struct packed {
        logic [1:0]        fmt;
        logic              three_color;
        logic [23:0]       e0;
        logic [23:0]       e1;
        logic [2:0][9:0]   sum_a;    // 2*e0 + e1 + 1
        logic [2:0][9:0]   sum_b;    // e0 + 2*e1 + 1
        logic [2:0][8:0]   sum_h;    // e0 + e1 + 1
        logic              alpha_gt;
        logic [5:0][10:0]  asum;     // alpha entries 2..7 before the divide
        logic [31:0]       cidx;
        logic [63:0]       ahalf;
    } sums_t;

    function automatic logic [23:0] widen565(input logic [15:0] c);
        logic [4:0] r;
        logic [5:0] g;
        logic [4:0] b;
        r = c[15:11];
        g = c[10:5];
        b = c[4:0];
        return {b, b[4:2], g, g[5:4], r, r[4:2]};
    endfunction

    sums_t          s1_reg, s1_next;
    logic           s1_valid_reg, s1_valid_next;
    bctd_pkg::pal_t pal_reg, pal_next;
    logic           pal_valid_reg, pal_valid_next;
    logic           in_xfer, pal_load;

    assign pal_load   = s1_valid_reg && (!pal_valid_reg || pal_ready_i);
    assign in_ready_o = !s1_valid_reg || pal_load;
    assign in_xfer    = in_valid_i && in_ready_o;

    always_comb begin
        logic [7:0] c0, c1, a0, a1;
        c0            = '0;
        c1            = '0;
        a0            = '0;
        a1            = '0;
        s1_next       = s1_reg;
        s1_valid_next = in_xfer ? 1'b1 : (pal_load ? 1'b0 : s1_valid_reg);
        if (in_xfer) begin
            s1_next.fmt         = fmt_i;
            s1_next.three_color = (fmt_i == bctd_pkg::FMT_BC1)
                                  && (color_half_i[15:0] <= color_half_i[31:16]);
            s1_next.e0          = widen565(color_half_i[15:0]);
            s1_next.e1          = widen565(color_half_i[31:16]);
            for (int ch = 0; ch < 3; ch++) begin
                c0 = s1_next.e0[8*ch +: 8];
                c1 = s1_next.e1[8*ch +: 8];
                s1_next.sum_a[ch] = 10'({c0, 1'b0}) + 10'(c1) + 10'd1;
                s1_next.sum_b[ch] = 10'(c0) + 10'({c1, 1'b0}) + 10'd1;
                s1_next.sum_h[ch] = 9'(c0) + 9'(c1) + 9'd1;
            end
            a0 = alpha_half_i[7:0];
            a1 = alpha_half_i[15:8];
            s1_next.alpha_gt = a0 > a1;
            for (int k = 2; k < 8; k++) begin
                if (a0 > a1) begin
                    s1_next.asum[k-2] = 11'(8 - k) * 11'(a0) + 11'(k - 1) * 11'(a1) + 11'd3;
                end else if (k < 6) begin
                    s1_next.asum[k-2] = 11'(6 - k) * 11'(a0) + 11'(k - 1) * 11'(a1) + 11'd2;
                end else begin
                    s1_next.asum[k-2] = '0;
                end
            end
            s1_next.cidx  = color_half_i[63:32];
            s1_next.ahalf = alpha_half_i;
        end
    end

    always_comb begin
        pal_next             = pal_reg;
        pal_valid_next       = pal_load ? 1'b1 : (pal_ready_i ? 1'b0 : pal_valid_reg);
        if (pal_load) begin
            pal_next.fmt         = s1_reg.fmt;
            pal_next.three_color = s1_reg.three_color;
            pal_next.rgb[0]      = s1_reg.e0;
            pal_next.rgb[1]      = s1_reg.e1;
            for (int ch = 0; ch < 3; ch++) begin
                if (s1_reg.three_color) begin
                    pal_next.rgb[2][8*ch +: 8] = s1_reg.sum_h[ch][8:1];
                    pal_next.rgb[3][8*ch +: 8] = 8'd0;
                end else begin
                    pal_next.rgb[2][8*ch +: 8] = bctd_pkg::div3(s1_reg.sum_a[ch]);
                    pal_next.rgb[3][8*ch +: 8] = bctd_pkg::div3(s1_reg.sum_b[ch]);
                end
            end
            pal_next.atab[0] = s1_reg.ahalf[7:0];
            pal_next.atab[1] = s1_reg.ahalf[15:8];
            for (int k = 2; k < 8; k++) begin
                if (s1_reg.alpha_gt) begin
                    pal_next.atab[k] = bctd_pkg::div7(s1_reg.asum[k-2]);
                end else if (k < 6) begin
                    pal_next.atab[k] = bctd_pkg::div5(s1_reg.asum[k-2]);
                end else begin
                    pal_next.atab[k] = (k == 6) ? 8'd0 : 8'd255;
                end
            end
            pal_next.cidx  = s1_reg.cidx;
            pal_next.ahalf = s1_reg.ahalf;
        end
    end

    always_ff @(posedge aclk) begin
        s1_reg  <= s1_next;
        pal_reg <= pal_next;
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            pal_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            pal_valid_reg <= pal_valid_next;
        end
    end

    assign pal_valid_o = pal_valid_reg;
    assign pal_o       = pal_reg;

endmodule

`default_nettype wire

@@ hw/rtl/bctd_lane.sv @@
// One column lane: palette lookup and alpha select for a single texel.
`timescale 1ns / 1ps
`default_nettype none

module bctd_lane (
    input  wire bctd_pkg::pal_t pal_i,
    input  wire logic [1:0]     cidx_i,
    input  wire logic [3:0]     a4_i,
    input  wire logic [2:0]     ai_i,
    output logic [31:0]         texel_o
);

    logic [7:0] alpha;

    always_comb begin
        case (pal_i.fmt)
            bctd_pkg::FMT_BC1: alpha = (pal_i.three_color && cidx_i == 2'd3) ? 8'd0 : 8'd255;
            bctd_pkg::FMT_BC2: alpha = {a4_i, a4_i};
            default:           alpha = pal_i.atab[ai_i];   // BC3 and the spare code
        endcase
    end

    assign texel_o = {alpha, pal_i.rgb[cidx_i]};

endmodule

`default_nettype wire

@@ hw/rtl/bc_texture_block_decoder_unit.sv @@
// Top level of the BC1/BC2/BC3 block decoder: config register, palette, four lanes, row register.
//
//  channel   dir  handshake           payload
//  s_        in   s_tvalid/s_tready   s_tdata: color_half, alpha_half
//  m_        out  m_tvalid/m_tready   m_tdata: row_number, texel0..3; m_tlast: last_row
//  cfg_      in   cfg_valid/cfg_ready cfg_data: block_format
//
// A block enters the palette sum stage, then the divide stage, which holds it while
// its four rows go out through the lanes into the output register, one row per cycle while m_
// is not stalled; the sum stage can take the next block meanwhile. The first row of a block
// reaches m_ through the sum register, the block register and the output register. A stalled m_ side holds the
// output row and backs up through the two palette stages to s_tready.
// Reset is synchronous: clears valid flags, the row counter and block_format (BC1).
`timescale 1ns / 1ps
`default_nettype none

module bc_texture_block_decoder_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [bctd_pkg::S_DATA_W-1:0] s_tdata,   // [63:0] color_half, [127:64] alpha_half
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [bctd_pkg::M_DATA_W-1:0]      m_tdata,   // [1:0] row_number, [33:2] texel0,
                                                          // [65:34] texel1, [97:66] texel2,
                                                          // [129:98] texel3, [135:130] zero
    output logic                               m_tlast,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [1:0]                    cfg_data
);

    logic [1:0]                    block_format_reg;
    bctd_pkg::pal_t                pal;
    logic                          pal_valid, pal_ready;
    logic [1:0]                    row_reg, row_next;
    logic                          out_open, emit;
    logic [bctd_pkg::M_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                          m_tvalid_reg, m_tvalid_next;
    logic                          m_tlast_reg, m_tlast_next;
    logic [7:0]                    row_cidx;
    logic [15:0]                   row_a4;
    logic [47:0]                   ai_all;
    logic [5:0]                    ai_base;
    logic [11:0]                   row_ai;
    logic [3:0][31:0]              texel;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_format_reg <= bctd_pkg::FMT_BC1;
        end else if (cfg_valid) begin
            block_format_reg <= cfg_data;
        end
    end

    bctd_palette u_palette (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .fmt_i        (block_format_reg),
        .in_valid_i   (s_tvalid),
        .in_ready_o   (s_tready),
        .color_half_i (s_tdata[63:0]),
        .alpha_half_i (s_tdata[127:64]),
        .pal_valid_o  (pal_valid),
        .pal_ready_i  (pal_ready),
        .pal_o        (pal)
    );

    // per-row slices of the index fields
    assign row_cidx = pal.cidx[{row_reg, 3'b000} +: 8];
    assign row_a4   = pal.ahalf[{row_reg, 4'b0000} +: 16];
    assign ai_all   = pal.ahalf[63:16];
    assign ai_base  = 6'({row_reg, 3'b000}) + 6'({row_reg, 2'b00});
    assign row_ai   = ai_all[ai_base +: 12];

    for (genvar c = 0; c < 4; c++) begin : g_lane
        bctd_lane u_lane (
            .pal_i   (pal),
            .cidx_i  (row_cidx[2*c +: 2]),
            .a4_i    (row_a4[4*c +: 4]),
            .ai_i    (row_ai[3*c +: 3]),
            .texel_o (texel[c])
        );
    end

    assign out_open  = !m_tvalid_reg || m_tready;
    assign emit      = pal_valid && out_open;
    assign pal_ready = emit && (row_reg == bctd_pkg::LAST_ROW);

    always_comb begin
        row_next      = row_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        if (emit) begin
            row_next      = row_reg + 2'd1;
            m_tdata_next  = {6'd0, texel[3], texel[2], texel[1], texel[0], row_reg};
            m_tlast_next  = (row_reg == bctd_pkg::LAST_ROW);
            m_tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
        if (!aresetn) begin
            row_reg      <= 2'd0;
            m_tvalid_reg <= 1'b0;
        end else begin
            row_reg      <= row_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

`default_nettype wire

@@ hw/rtl/bctd_checker.sv @@
// Port-level checker for the block decoder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module bctd_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [bctd_pkg::M_DATA_W-1:0] m_tdata,
    input wire logic                          m_tlast
);

    logic [4:0] pend_reg, pend_next;   // rows owed for blocks taken in
    logic [1:0] exp_row_reg;

    always_comb begin
        pend_next = pend_reg;
        if (s_tvalid && s_tready) begin
            pend_next = pend_next + 5'd4;
        end
        if (m_tvalid && m_tready) begin
            pend_next = pend_next - 5'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg    <= 5'd0;
            exp_row_reg <= 2'd0;
        end else begin
            pend_reg <= pend_next;
            if (m_tvalid && m_tready) begin
                exp_row_reg <= exp_row_reg + 2'd1;
            end
        end
    end

    a_last_on_row3: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tdata[1:0] == bctd_pkg::LAST_ROW)))
        else $error("tlast does not match row 3");

    a_row_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[1:0] == exp_row_reg))
        else $error("rows out of order");

    a_no_extra_rows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (pend_reg != 5'd0))
        else $error("row with no block behind it");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("output changed while stalled");

endmodule

bind bc_texture_block_decoder_unit bctd_checker u_bctd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
